// ----- rtl/thts_pkg.sv -----
// shared constants, types and sine table for the three-harmonic tone synthesizer
package thts_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int IDX_SHIFT       = PHASE_BITS - TABLE_ADDR_BITS - 2;
  localparam int QTR_SIZE        = 1 << TABLE_ADDR_BITS;
  localparam int ROM_DEPTH       = QTR_SIZE + 1;
  localparam int ROM_ADDR_W      = TABLE_ADDR_BITS + 1;
  localparam int SINE_W          = 15;
  localparam int AMP_W           = 15;
  localparam int PROD_W          = AMP_W + SINE_W;
  localparam int SAMPLE_W        = 16;
  localparam int SUM_W           = SAMPLE_W + 2;
  localparam int NUM_HARM        = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [SINE_W-1:0]     sine_t;
  typedef sine_t                 rom_t [ROM_DEPTH];

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATE_MIX = 2'd2;

  localparam phase_t             PHASE_STEP_RST = phase_t'(42852281);
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = AMP_W'(20000);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic             saturate_mix;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // quarter-wave sine in q0.15 from a seven-term taylor series in q2.30
  function automatic rom_t build_sine_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    longint      q;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x  = (64'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - longint'(t);
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + longint'(t);
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - longint'(t);
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + longint'(t);
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - longint'(t);
      t  = ((t * x2) >> 30) / 64'd156;
      s  = s + longint'(t);
      if (s < 0) begin
        s = 0;
      end
      q = (s + 64'sd16384) >>> 15;
      if (q > 32767) begin
        q = 32767;
      end
      rom[k] = q[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/thts_rom.sv -----
// quarter-wave sine rom with one registered read port
module thts_rom (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [thts_pkg::ROM_ADDR_W-1:0] addr_i,
  output thts_pkg::sine_t                 data_o
);

  thts_pkg::sine_t data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= thts_pkg::SINE_ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ----- rtl/thts_queue.sv -----
// short phase queue between the front end and the synthesis pipeline
module thts_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  thts_pkg::phase_t         push_data_i,
  input  logic                     pop_i,
  output thts_pkg::phase_t         head_o,
  output thts_pkg::queue_status_t  status_o
);

  thts_pkg::phase_t mem_q [thts_pkg::QUEUE_DEPTH];

  logic [thts_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [thts_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [thts_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign status_o.full  = (cnt_q == thts_pkg::QUEUE_CNT_W'(thts_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/thts_front.sv -----
// front end: configuration registers, input handshake and phase accumulator
module thts_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [thts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [thts_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  input  thts_pkg::queue_status_t         q_status_i,
  output logic                            push_o,
  output thts_pkg::phase_t                push_data_o,
  output thts_pkg::cfg_t                  cfg_o
);

  thts_pkg::phase_t                  phase_q, phase_d;
  thts_pkg::phase_t                  step_q, step_d;
  logic [thts_pkg::AMP_W-1:0]        amp_q, amp_d;
  logic                              sat_q, sat_d;
  thts_pkg::phase_t                  cur_phase;

  assign in_ready_o  = !q_status_i.full;
  assign push_o      = in_valid_i && in_ready_o;
  assign cur_phase   = restart_i ? '0 : phase_q;
  assign push_data_o = cur_phase;
  assign cfg_o.amplitude    = amp_q;
  assign cfg_o.saturate_mix = sat_q;

  always_comb begin
    phase_d = push_o ? cur_phase + step_q : phase_q;
    step_d  = step_q;
    amp_d   = amp_q;
    sat_d   = sat_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        thts_pkg::CFG_PHASE_STEP:   step_d = thts_pkg::phase_t'(cfg_wdata_i);
        thts_pkg::CFG_AMPLITUDE:    amp_d  = cfg_wdata_i[thts_pkg::AMP_W-1:0];
        thts_pkg::CFG_SATURATE_MIX: sat_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= thts_pkg::PHASE_STEP_RST;
      amp_q   <= thts_pkg::AMPLITUDE_RST;
      sat_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      amp_q   <= amp_d;
      sat_q   <= sat_d;
    end
  end

endmodule

// ----- rtl/thts_back.sv -----
// back end: harmonic phases, table lookup, scaling and mix pipeline
module thts_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  thts_pkg::phase_t                      q_head_i,
  input  thts_pkg::queue_status_t               q_status_i,
  output logic                                  pop_o,
  input  thts_pkg::cfg_t                        cfg_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  fundamental_o,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  second_harmonic_o,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  third_harmonic_o,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  mixed_sample_o
);

  localparam int T  = thts_pkg::TABLE_ADDR_BITS;
  localparam int PB = thts_pkg::PHASE_BITS;
  localparam int N  = thts_pkg::NUM_HARM;
  localparam logic [thts_pkg::ROM_ADDR_W-1:0] QtrAddr =
    thts_pkg::ROM_ADDR_W'(thts_pkg::QTR_SIZE);

  logic adv;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  thts_pkg::phase_t                       ph_q     [N];
  logic [thts_pkg::ROM_ADDR_W-1:0]        rom_addr [N];
  thts_pkg::sine_t                        rom_data [N];
  logic                                   neg2_q   [N];
  logic                                   neg3_q   [N];
  logic [thts_pkg::PROD_W-1:0]            prod_q   [N];
  logic signed [thts_pkg::SAMPLE_W-1:0]   scaled_q [N];
  logic signed [thts_pkg::SAMPLE_W-1:0]   scaled_d [N];

  logic signed [thts_pkg::SUM_W-1:0]      sum;
  logic signed [thts_pkg::SAMPLE_W-1:0]   mix_d;
  logic signed [thts_pkg::SAMPLE_W-1:0]   f_q, s_q, t_q, m_q;

  // whole pipeline moves unless the output holds an unaccepted item
  assign adv   = !v5_q || out_ready_i;
  assign pop_o = adv && !q_status_i.empty;

  for (genvar g = 0; g < N; g++) begin : g_lane
    logic [T-1:0] idx;
    logic [1:0]   quad;
    logic [thts_pkg::PROD_W-1:0]    prod_d;
    logic [thts_pkg::SINE_W-1:0]    mag;

    assign idx  = ph_q[g][thts_pkg::IDX_SHIFT +: T];
    assign quad = ph_q[g][PB-1 -: 2];
    // odd quadrants read the table mirrored
    assign rom_addr[g] = quad[0] ? (QtrAddr - {1'b0, idx}) : {1'b0, idx};

    thts_rom u_rom (
      .clk_i  (clk_i),
      .en_i   (adv),
      .addr_i (rom_addr[g]),
      .data_o (rom_data[g])
    );

    assign prod_d = thts_pkg::PROD_W'(cfg_i.amplitude) * thts_pkg::PROD_W'(rom_data[g]);
    assign mag    = prod_q[g][thts_pkg::PROD_W-1 -: thts_pkg::SINE_W];
    // truncation toward zero: scale the magnitude, then apply the sign
    assign scaled_d[g] = neg3_q[g] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg2_q[g]   <= quad[1];
        neg3_q[g]   <= neg2_q[g];
        prod_q[g]   <= prod_d;
        scaled_q[g] <= scaled_d[g];
      end
    end
  end

  assign sum = thts_pkg::SUM_W'(scaled_q[0]) + thts_pkg::SUM_W'(scaled_q[1])
             + thts_pkg::SUM_W'(scaled_q[2]);

  always_comb begin
    mix_d = sum[thts_pkg::SAMPLE_W-1:0];
    if (cfg_i.saturate_mix) begin
      if (sum > thts_pkg::SUM_W'(32767)) begin
        mix_d = 16'sh7fff;
      end else if (sum < -thts_pkg::SUM_W'(32768)) begin
        mix_d = 16'sh8000;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q[0] <= q_head_i;
      ph_q[1] <= {q_head_i[PB-2:0], 1'b0};
      ph_q[2] <= q_head_i + {q_head_i[PB-2:0], 1'b0};
      f_q     <= scaled_q[0];
      s_q     <= scaled_q[1];
      t_q     <= scaled_q[2];
      m_q     <= mix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign out_valid_o       = v5_q;
  assign fundamental_o     = f_q;
  assign second_harmonic_o = s_q;
  assign third_harmonic_o  = t_q;
  assign mixed_sample_o    = m_q;

endmodule

// ----- rtl/three_harmonic_tone_synthesizer.sv -----
// three-harmonic tone synthesizer top level: front end, phase queue and synthesis pipeline
// path: queue, then the phase, rom, product, scaled and output registers of the pipeline
// one item per cycle when unstalled; a 4-entry queue lets input and output stall apart
// the pipeline depth is set by the registered sine table read and the 15x15 scaling multiply
// reset: phase cleared, registers to their defaults, queue and pipeline empty, no table clear
module three_harmonic_tone_synthesizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [thts_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [thts_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  fundamental_o,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  second_harmonic_o,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  third_harmonic_o,
  output logic signed [thts_pkg::SAMPLE_W-1:0]  mixed_sample_o
);

  logic                     push;
  logic                     pop;
  thts_pkg::phase_t         push_data;
  thts_pkg::phase_t         q_head;
  thts_pkg::queue_status_t  q_status;
  thts_pkg::cfg_t           cfg;

  thts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data),
    .cfg_o       (cfg)
  );

  thts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  thts_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_head_i          (q_head),
    .q_status_i        (q_status),
    .pop_o             (pop),
    .cfg_i             (cfg),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fundamental_o     (fundamental_o),
    .second_harmonic_o (second_harmonic_o),
    .third_harmonic_o  (third_harmonic_o),
    .mixed_sample_o    (mixed_sample_o)
  );

  // in wrap mode the mix is the 16-bit sum of the three harmonics
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cfg.saturate_mix |->
      mixed_sample_o == 16'(fundamental_o + second_harmonic_o + third_harmonic_o))
    else $error("mixed sample does not match harmonic sum");

  // a pushed item leaves the queue non-empty at the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && q_status.empty |=> !q_status.empty)
    else $error("queue lost a pushed item");

  // scaled sines never reach the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fundamental_o != 16'sh8000 && second_harmonic_o != 16'sh8000
                    && third_harmonic_o != 16'sh8000)
    else $error("harmonic out of range");

endmodule
